// File: design/dd_pkg.sv
package dd_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_PROCESSES_DEF = 16;
  localparam int MAX_RESOURCES_DEF = 8;
  localparam int AMOUNT_WIDTH_DEF  = 16;

  // fixed field widths
  localparam int OP_W        = 2;
  localparam int PIDX_W      = 4;
  localparam int RIDX_W      = 3;
  localparam int PCNT_W      = 5;
  localparam int RCNT_W      = 4;
  localparam int BCNT_W      = 5;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // configuration reset values
  localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(16);
  localparam logic [RCNT_W-1:0] RCNT_RESET = RCNT_W'(8);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_COUNT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_RESOURCE_COUNT = CFG_INDEX_W'(1);

  // item operation codes
  localparam logic [OP_W-1:0] OP_TOTAL   = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd2;
  localparam logic [OP_W-1:0] OP_START   = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // write a load item into its store
    logic start;     // capture counts, clear i, j and the nonzero marks
    logic wk_total;  // work[j] = total[j]
    logic rd;        // read request and allocation at (i, j)
    logic av_sub;    // work[j] -= alloc, note nonzero allocation
    logic av_add;    // work[j] += alloc
    logic chk;       // fit &= request <= work[j]
    logic mark_init; // finished = all-zero allocation
    logic fin_set;   // mark process i finished
    logic fit_set;
    logic chg_set;
    logic chg_clr;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic cnt_clr;
    logic cnt_add;   // count process i if unmarked
    logic res_wr;    // load the result register
  } dd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic i_end;
    logic j_end;
    logic fin_cur;
    logic fit;
    logic changed;
    logic out_busy;
  } dd_sts_t;

endpackage

// File: design/dd_ctrl.sv
module dd_ctrl
  import dd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_is_start,
  output logic    in_ready,
  input  dd_sts_t sts,
  output dd_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AV_COL,
    S_AV_RD,
    S_AV_ACC,
    S_SC_PROC,
    S_SC_RD,
    S_SC_CHK,
    S_AD_RD,
    S_AD_ACC,
    S_CNT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_is_start) begin
          cmd.start = 1'b1;
          state_nxt = S_AV_COL;
        end else if (in_valid) begin
          cmd.load = 1'b1;
        end
      end
      // available = total minus column sum of allocations
      S_AV_COL: begin
        if (sts.j_end) begin
          cmd.mark_init = 1'b1;
          cmd.chg_clr   = 1'b1;
          cmd.i_clr     = 1'b1;
          state_nxt     = S_SC_PROC;
        end else begin
          cmd.wk_total = 1'b1;
          cmd.i_clr    = 1'b1;
          state_nxt    = S_AV_RD;
        end
      end
      S_AV_RD: begin
        if (sts.i_end) begin
          cmd.j_inc = 1'b1;
          state_nxt = S_AV_COL;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_AV_ACC;
        end
      end
      S_AV_ACC: begin
        cmd.av_sub = 1'b1;
        cmd.i_inc  = 1'b1;
        state_nxt  = S_AV_RD;
      end
      // sweep processes until a whole pass marks nothing
      S_SC_PROC: begin
        if (sts.i_end) begin
          cmd.i_clr = 1'b1;
          if (sts.changed) begin
            cmd.chg_clr = 1'b1;
          end else begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_CNT;
          end
        end else if (sts.fin_cur) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.j_clr   = 1'b1;
          cmd.fit_set = 1'b1;
          state_nxt   = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (sts.j_end) begin
          if (sts.fit) begin
            cmd.j_clr = 1'b1;
            state_nxt = S_AD_RD;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = S_SC_PROC;
          end
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        cmd.chk   = 1'b1;
        cmd.j_inc = 1'b1;
        state_nxt = S_SC_RD;
      end
      // release the allocation of a process that fits
      S_AD_RD: begin
        if (sts.j_end) begin
          cmd.fin_set = 1'b1;
          cmd.chg_set = 1'b1;
          cmd.i_inc   = 1'b1;
          state_nxt   = S_SC_PROC;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_AD_ACC;
        end
      end
      S_AD_ACC: begin
        cmd.av_add = 1'b1;
        cmd.j_inc  = 1'b1;
        state_nxt  = S_AD_RD;
      end
      // count unmarked processes, then post the result
      S_CNT: begin
        if (!sts.i_end) begin
          cmd.cnt_add = 1'b1;
          cmd.i_inc   = 1'b1;
        end else if (!sts.out_busy) begin
          cmd.res_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/dd_datapath.sv
module dd_datapath
  import dd_pkg::*;
#(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
  parameter int AMOUNT_WIDTH  = AMOUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [OP_W-1:0]         ld_op,
  input  logic [PIDX_W-1:0]       ld_pidx,
  input  logic [RIDX_W-1:0]       ld_ridx,
  input  logic [AMOUNT_WIDTH-1:0] ld_amount,
  input  dd_cmd_t                 cmd,
  output dd_sts_t                 sts,
  input  logic                    out_tready,
  output logic                    out_valid,
  output logic                    out_deadlocked,
  output logic [BCNT_W-1:0]       out_blocked_count
);

  localparam int PW  = $clog2(MAX_PROCESSES);
  localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW = $clog2(MAX_PROCESSES + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);
  // work spans total down to total minus every allocation
  localparam int WW  = AMOUNT_WIDTH + PW + 1;

  // configuration
  logic [PCNT_W-1:0] pcnt_r;
  logic [RCNT_W-1:0] rcnt_r;

  // detection control
  logic [PCW-1:0] np_r, i_r, cnt_r;
  logic [RCW-1:0] nr_r, j_r;
  logic           fit_r, chg_r;
  logic [MAX_PROCESSES-1:0] nz_r, fin_r;

  // stores
  logic [AMOUNT_WIDTH-1:0] total_r [MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] req_mem [MAX_PROCESSES][MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] alc_mem [MAX_PROCESSES][MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] req_q, alc_q;
  logic signed [WW-1:0]    work_r [MAX_RESOURCES];

  // result register
  logic              out_valid_r;
  logic              dead_r;
  logic [BCNT_W-1:0] bcnt_r;

  logic [PW-1:0]        i_idx;
  logic [RW-1:0]        j_idx;
  logic                 ld_p_ok, ld_r_ok;
  logic [PW-1:0]        ld_p;
  logic [RW-1:0]        ld_r;
  logic signed [WW-1:0] work_cur, req_ext, alc_ext, tot_ext;

  assign i_idx    = i_r[PW-1:0];
  assign j_idx    = j_r[RW-1:0];
  assign ld_p_ok  = (32'(ld_pidx) < MAX_PROCESSES);
  assign ld_r_ok  = (32'(ld_ridx) < MAX_RESOURCES);
  assign ld_p     = PW'(ld_pidx);
  assign ld_r     = RW'(ld_ridx);
  assign work_cur = work_r[j_idx];
  assign req_ext  = $signed({{(WW-AMOUNT_WIDTH){1'b0}}, req_q});
  assign alc_ext  = $signed({{(WW-AMOUNT_WIDTH){1'b0}}, alc_q});
  assign tot_ext  = $signed({{(WW-AMOUNT_WIDTH){1'b0}}, total_r[j_idx]});

  // status back to the controller
  always_comb begin
    sts.i_end    = (i_r == np_r);
    sts.j_end    = (j_r == nr_r);
    sts.fin_cur  = fin_r[i_idx];
    sts.fit      = fit_r;
    sts.changed  = chg_r;
    sts.out_busy = out_valid_r && !out_tready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= PCNT_RESET;
      rcnt_r <= RCNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PROCESS_COUNT:  pcnt_r <= cfg_data[PCNT_W-1:0];
        CFG_RESOURCE_COUNT: rcnt_r <= cfg_data[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // counters, flags and marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r  <= '0;
      nr_r  <= '0;
      i_r   <= '0;
      j_r   <= '0;
      cnt_r <= '0;
      fit_r <= 1'b0;
      chg_r <= 1'b0;
      nz_r  <= '0;
      fin_r <= '0;
    end else begin
      if (cmd.start) begin
        np_r <= (32'(pcnt_r) > MAX_PROCESSES) ? PCW'(MAX_PROCESSES) : PCW'(pcnt_r);
        nr_r <= (32'(rcnt_r) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(rcnt_r);
        nz_r <= '0;
      end
      if (cmd.start || cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + PCW'(1);
      end
      if (cmd.start || cmd.j_clr) begin
        j_r <= '0;
      end else if (cmd.j_inc) begin
        j_r <= j_r + RCW'(1);
      end
      if (cmd.av_sub && (alc_q != '0)) begin
        nz_r[i_idx] <= 1'b1;
      end
      if (cmd.mark_init) begin
        fin_r <= ~nz_r;
      end else if (cmd.fin_set) begin
        fin_r[i_idx] <= 1'b1;
      end
      if (cmd.fit_set) begin
        fit_r <= 1'b1;
      end else if (cmd.chk && (req_ext > work_cur)) begin
        fit_r <= 1'b0;
      end
      if (cmd.chg_clr) begin
        chg_r <= 1'b0;
      end else if (cmd.chg_set) begin
        chg_r <= 1'b1;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_add && !fin_r[i_idx]) begin
        cnt_r <= cnt_r + PCW'(1);
      end
    end
  end

  // total amounts
  always_ff @(posedge clk) begin
    if (cmd.load && (ld_op == OP_TOTAL) && ld_r_ok) begin
      total_r[ld_r] <= ld_amount;
    end
  end

  // request matrix, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && (ld_op == OP_REQUEST) && ld_p_ok && ld_r_ok) begin
      req_mem[ld_p][ld_r] <= ld_amount;
    end
    if (cmd.rd) begin
      req_q <= req_mem[i_idx][j_idx];
    end
  end

  // allocation matrix, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && (ld_op == OP_ALLOC) && ld_p_ok && ld_r_ok) begin
      alc_mem[ld_p][ld_r] <= ld_amount;
    end
    if (cmd.rd) begin
      alc_q <= alc_mem[i_idx][j_idx];
    end
  end

  // work vector
  always_ff @(posedge clk) begin
    if (cmd.wk_total) begin
      work_r[j_idx] <= tot_ext;
    end else if (cmd.av_sub) begin
      work_r[j_idx] <= work_cur - alc_ext;
    end else if (cmd.av_add) begin
      work_r[j_idx] <= work_cur + alc_ext;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      dead_r <= (cnt_r != '0);
      bcnt_r <= BCNT_W'(cnt_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_deadlocked    = dead_r;
  assign out_blocked_count = bcnt_r;

`ifndef SYNTHESIS
  a_fin_needs_fit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_set |-> fit_r)
    else $error("process marked without a fitting request");
  a_i_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    i_r <= np_r)
    else $error("process counter past process count");
  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    j_r <= nr_r)
    else $error("resource counter past resource count");
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (i_r < np_r) && (j_r < nr_r))
    else $error("matrix read outside the active region");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_wr |-> !(out_valid_r && !out_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule

// File: design/deadlock_detector_core.sv
// Multi-instance deadlock detector. Load items (op 0 total, 1 request, 2 allocation) give
// no result; indexes at or past the maximum sizes are dropped. A start item (op 3) runs
// detection and gives one item with the deadlock flag and the number of blocked processes.
// Detection forms the available vector from the totals and the allocations, then sweeps
// over the P processes and R resources in use, marking each process whose request fits
// and releasing its allocation, until a sweep marks no process, and then counts the
// unmarked processes; the request and allocation memories are read one entry at a time.
// A finished result waits in an output register, and loads are taken meanwhile; the next
// detection holds its result until that register is free. Request and allocation entries
// in use must be written before a start.
module deadlock_detector_core
  import dd_pkg::*;
#(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
  parameter int AMOUNT_WIDTH  = AMOUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // op
  input  logic [OP_W-1:0]        in_tuser,
  // process_index, resource_index, amount
  input  logic [((PIDX_W + RIDX_W + AMOUNT_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // deadlocked, blocked_count
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RIDX_LSB = PIDX_W;
  localparam int AMT_LSB  = PIDX_W + RIDX_W;

  logic [OP_W-1:0]         in_op;
  logic [PIDX_W-1:0]       in_pidx;
  logic [RIDX_W-1:0]       in_ridx;
  logic [AMOUNT_WIDTH-1:0] in_amount;
  logic                    res_dead;
  logic [BCNT_W-1:0]       res_bcnt;
  dd_cmd_t                 cmd;
  dd_sts_t                 sts;

  // unpack input item
  assign in_op     = in_tuser;
  assign in_pidx   = in_tdata[PIDX_W-1:0];
  assign in_ridx   = in_tdata[RIDX_LSB +: RIDX_W];
  assign in_amount = in_tdata[AMT_LSB +: AMOUNT_WIDTH];

  assign cfg_ready = 1'b1;

  dd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_is_start (in_op == OP_START),
    .in_ready    (in_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  dd_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .AMOUNT_WIDTH  (AMOUNT_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ld_op             (in_op),
    .ld_pidx           (in_pidx),
    .ld_ridx           (in_ridx),
    .ld_amount         (in_amount),
    .cmd               (cmd),
    .sts               (sts),
    .out_tready        (out_tready),
    .out_valid         (out_tvalid),
    .out_deadlocked    (res_dead),
    .out_blocked_count (res_bcnt)
  );

  // pack result item
  assign out_tdata = {{(OUT_TDATA_W - BCNT_W - 1){1'b0}}, res_bcnt, res_dead};

endmodule

// File: sim/deadlock_detector_core_test.sv
module deadlock_detector_core_test;
  import dd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPROC = MAX_PROCESSES_DEF;
  localparam int NRES  = MAX_RESOURCES_DEF;
  localparam int AMT_W = AMOUNT_WIDTH_DEF;

  // one input item, op in the lowest bits
  typedef struct packed {
    logic [AMT_W-1:0]  amount;
    logic [RIDX_W-1:0] res;
    logic [PIDX_W-1:0] proc;
    logic [OP_W-1:0]   op;
  } cmd_item_t;

  localparam int ITEM_W = $bits(cmd_item_t);
  localparam int DATA_W = ITEM_W - OP_W;
  localparam int IN_W   = ((DATA_W + 7) / 8) * 8;

  // one result item
  typedef struct packed {
    logic [BCNT_W-1:0] blocked;
    logic              dead;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OP_W-1:0]        in_tuser = '0;
  logic [IN_W-1:0]        in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  deadlock_detector_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // items waiting to be sent and verdicts waiting to come back
  cmd_item_t cmd_q[$];
  verdict_t  verdict_q[$];
  int        item_total = 0;
  int        errors = 0;
  int        idle_odds = 4;

  // predicted block state
  logic [PCNT_W-1:0] proc_count = PCNT_RESET;
  logic [RCNT_W-1:0] res_count  = RCNT_RESET;
  logic [AMT_W-1:0]  tot_q [NRES];
  logic [AMT_W-1:0]  req_q [NPROC][NRES];
  logic [AMT_W-1:0]  alc_q [NPROC][NRES];

  // entries that queued items will have written
  bit tot_w [NRES];
  bit req_w [NPROC][NRES];
  bit alc_w [NPROC][NRES];

  // detection over the stores with the current counts
  function automatic verdict_t detect_deadlock();
    int       np;
    int       nr;
    int       blocked;
    longint   work [NRES];
    longint   amt;
    bit       done [NPROC];
    bit       zero;
    bit       fits;
    bit       changed;
    verdict_t v;
    np = (proc_count > NPROC) ? NPROC : int'(proc_count);
    nr = (res_count > NRES) ? NRES : int'(res_count);
    // available = total minus column sums of allocation
    for (int j = 0; j < nr; j++) begin
      work[j] = tot_q[j];
      for (int i = 0; i < np; i++) begin
        amt = alc_q[i][j];
        work[j] = work[j] - amt;
      end
    end
    // processes holding nothing are finished up front
    for (int i = 0; i < NPROC; i++) begin
      zero = 1'b1;
      if (i < np) begin
        for (int j = 0; j < nr; j++)
          if (alc_q[i][j] != 0) zero = 1'b0;
      end
      done[i] = (i < np) && zero;
    end
    // sweep until no process gets marked
    do begin
      changed = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++) begin
            amt = req_q[i][j];
            if (amt > work[j]) fits = 1'b0;
          end
          if (fits) begin
            done[i] = 1'b1;
            for (int j = 0; j < nr; j++) begin
              amt = alc_q[i][j];
              work[j] = work[j] + amt;
            end
            changed = 1'b1;
          end
        end
      end
    end while (changed);
    blocked = 0;
    for (int i = 0; i < np; i++)
      if (!done[i]) blocked++;
    v.dead    = (blocked != 0);
    v.blocked = blocked[BCNT_W-1:0];
    return v;
  endfunction

  // apply one accepted item to the predicted state
  function automatic void absorb_item(cmd_item_t it);
    case (it.op)
      OP_TOTAL:   tot_q[it.res] = it.amount;
      OP_REQUEST: req_q[it.proc][it.res] = it.amount;
      OP_ALLOC:   alc_q[it.proc][it.res] = it.amount;
      default:    verdict_q.push_back(detect_deadlock());
    endcase
  endfunction

  // input driver
  cmd_item_t bus_item;
  int        in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_item(bus_item);
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          in_gap = $urandom_range(1, 19) - 1;
          in_tvalid <= 1'b0;
        end else begin
          bus_item = cmd_q.pop_front();
          in_tuser <= bus_item.op;
          in_tdata <= {{(IN_W - DATA_W){1'b0}}, bus_item.amount, bus_item.res,
                       bus_item.proc};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // result monitor with random back-pressure
  verdict_t got;
  int       out_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result item with nothing expected, tdata %h", out_tdata);
          errors++;
        end else begin
          got = verdict_q.pop_front();
          if (out_tdata[0] !== got.dead) begin
            $error("deadlocked: expected %0d, actual %0d", got.dead, out_tdata[0]);
            errors++;
          end
          if (out_tdata[BCNT_W:1] !== got.blocked) begin
            $error("blocked_count: expected %0d, actual %0d", got.blocked,
                   out_tdata[BCNT_W:1]);
            errors++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds * 4) == 1) begin
        out_gap = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // generous upper bound on run time
  initial begin
    #100000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_amount(int hi);
    if ($urandom_range(0, 11) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, hi);
  endfunction

  function automatic void push_item(logic [OP_W-1:0] op, int p, int r, int amt);
    cmd_item_t it;
    it.op     = op;
    it.proc   = p[PIDX_W-1:0];
    it.res    = r[RIDX_W-1:0];
    it.amount = amt[AMT_W-1:0];
    case (op)
      OP_TOTAL:   tot_w[r] = 1'b1;
      OP_REQUEST: req_w[p][r] = 1'b1;
      OP_ALLOC:   alc_w[p][r] = 1'b1;
      default:    ;
    endcase
    cmd_q.push_back(it);
    item_total++;
  endfunction

  // write whatever detection would read that was never written, then start
  function automatic void queue_start(int np, int nr);
    for (int j = 0; j < nr; j++)
      if (!tot_w[j]) push_item(OP_TOTAL, 0, j, pick_amount(6));
    for (int i = 0; i < np; i++) begin
      for (int j = 0; j < nr; j++) begin
        if (!alc_w[i][j]) push_item(OP_ALLOC, i, j, pick_amount(2));
        if (!req_w[i][j]) push_item(OP_REQUEST, i, j, pick_amount(3));
      end
    end
    push_item(OP_START, $urandom_range(0, NPROC - 1), $urandom_range(0, NRES - 1),
              $urandom_range(0, 65535));
  endfunction

  // a fresh matrix set, totals shaped around the allocation sums
  function automatic void queue_full_set(int np, int nr);
    longint colsum [NRES];
    longint t;
    int     a;
    for (int j = 0; j < NRES; j++) colsum[j] = 0;
    for (int i = 0; i < np; i++) begin
      for (int j = 0; j < nr; j++) begin
        a = ($urandom_range(0, 2) == 0) ? 0 : pick_amount(3);
        colsum[j] += a;
        push_item(OP_ALLOC, i, j, a);
        push_item(OP_REQUEST, i, j, pick_amount(4));
      end
    end
    for (int j = 0; j < nr; j++) begin
      if (colsum[j] > 65535) colsum[j] = 65535;
      // sometimes no more than the allocations, so available can go negative
      if ($urandom_range(0, 7) == 0) t = $urandom_range(0, int'(colsum[j]));
      else t = colsum[j] + $urandom_range(0, 3);
      if (t > 65535) t = 65535;
      push_item(OP_TOTAL, 0, j, int'(t));
    end
  endfunction

  // a few rewritten entries, inside the region in use when it is not empty
  function automatic void queue_partial(int np, int nr);
    int p;
    int r;
    repeat ($urandom_range(1, 4)) begin
      p = (np != 0) ? $urandom_range(0, np - 1) : $urandom_range(0, NPROC - 1);
      r = (nr != 0) ? $urandom_range(0, nr - 1) : $urandom_range(0, NRES - 1);
      case ($urandom_range(0, 2))
        0:       push_item(OP_TOTAL, 0, r, pick_amount(8));
        1:       push_item(OP_REQUEST, p, r, pick_amount(4));
        default: push_item(OP_ALLOC, p, r, pick_amount(3));
      endcase
    end
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PROCESS_COUNT) proc_count = val[PCNT_W-1:0];
    else if (idx == CFG_RESOURCE_COUNT) res_count = val[RCNT_W-1:0];
    @(negedge clk);
  endtask

  // all items sent, all verdicts back, then let trailing loads settle
  task automatic wait_idle();
    do @(negedge clk); while (cmd_q.size() != 0 || in_tvalid || verdict_q.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  // stimulus sequence
  initial begin
    int np_raw;
    int nr_raw;
    int np;
    int nr;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // two processes, one resource at full scale: p1 holds all of it
    write_reg(CFG_PROCESS_COUNT, 8'd2);
    write_reg(CFG_RESOURCE_COUNT, 8'd1);
    push_item(OP_TOTAL, 0, 0, 65535);
    push_item(OP_ALLOC, 0, 0, 0);
    push_item(OP_ALLOC, 1, 0, 65535);
    push_item(OP_REQUEST, 0, 0, 65535);
    push_item(OP_REQUEST, 1, 0, 0);
    queue_start(2, 1);
    // p1 asks one more than is free
    push_item(OP_REQUEST, 1, 0, 1);
    queue_start(2, 1);
    // available below zero
    push_item(OP_TOTAL, 0, 0, 0);
    push_item(OP_ALLOC, 1, 0, 5);
    push_item(OP_REQUEST, 1, 0, 0);
    queue_start(2, 1);
    // p0 only fits on the second sweep, after p1 returns its unit
    push_item(OP_TOTAL, 0, 0, 2);
    push_item(OP_ALLOC, 0, 0, 1);
    push_item(OP_ALLOC, 1, 0, 1);
    push_item(OP_REQUEST, 0, 0, 1);
    queue_start(2, 1);
    wait_idle();
    // no processes in use
    write_reg(CFG_PROCESS_COUNT, 8'd0);
    queue_start(0, 1);
    wait_idle();
    // no resources in use
    write_reg(CFG_PROCESS_COUNT, 8'd3);
    write_reg(CFG_RESOURCE_COUNT, 8'd0);
    queue_start(3, 0);
    wait_idle();

    // random phases, mostly small sizes
    while (item_total < 1450) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       np_raw = 0;
          1:       np_raw = NPROC;
          default: np_raw = $urandom_range(NPROC + 1, 31);
        endcase
        case ($urandom_range(0, 2))
          0:       nr_raw = 0;
          1:       nr_raw = NRES;
          default: nr_raw = $urandom_range(NRES + 1, 15);
        endcase
      end else begin
        np_raw = $urandom_range(1, 6);
        nr_raw = $urandom_range(1, 4);
      end
      // upper data bits carry noise that the register drops
      write_reg(CFG_PROCESS_COUNT, {3'($urandom_range(0, 7)), 5'(np_raw)});
      write_reg(CFG_RESOURCE_COUNT, {4'($urandom_range(0, 15)), 4'(nr_raw)});
      np = (np_raw > NPROC) ? NPROC : np_raw;
      nr = (nr_raw > NRES) ? NRES : nr_raw;
      if (item_total >= 1300) idle_odds = 0;
      else
        case ($urandom_range(0, 3))
          0:       idle_odds = 0;
          1:       idle_odds = 4;
          default: idle_odds = 10;
        endcase
      repeat ($urandom_range(1, 4)) begin
        if (np * nr <= 12 && $urandom_range(0, 2) != 0) queue_full_set(np, nr);
        else queue_partial(np, nr);
        // stray loads anywhere in the stores
        repeat ($urandom_range(0, 3))
          push_item(2'($urandom_range(OP_TOTAL, OP_ALLOC)), $urandom_range(0, NPROC - 1),
                    $urandom_range(0, NRES - 1), $urandom_range(0, 65535));
        queue_start(np, nr);
        if ($urandom_range(0, 5) == 0) queue_start(np, nr);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/dd_pkg.sv
design/dd_ctrl.sv
design/dd_datapath.sv
design/deadlock_detector_core.sv
sim/deadlock_detector_core_test.sv
